### hdl/u8u16_pkg.sv
package u8u16_pkg;

    // Most units a single input byte can cause: three replacements and a terminator.
    localparam int MAX_UNITS = 4;
    localparam int IDX_W     = $clog2(MAX_UNITS);
    localparam int TOTAL_W   = 32;

    // Unit values.
    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] TERM_UNIT    = 16'h0000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Code point limits.
    localparam logic [20:0] TWO_BYTE_MIN   = 21'h000080;
    localparam logic [20:0] THREE_BYTE_MIN = 21'h000800;
    localparam logic [20:0] SURR_FIRST     = 21'h00D800;
    localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h010000;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;

    // Continuation byte pattern 10xxxxxx.
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Up to four units produced by one decoded byte.
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [IDX_W-1:0]           last_idx;
        logic                       term;
        logic [TOTAL_W-1:0]         total;
    } batch_t;

endpackage

### hdl/u8u16_decode.sv
module u8u16_decode #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [7:0]        in_byte,
    output logic              has_result,
    output u8u16_pkg::batch_t batch
);
    import u8u16_pkg::*;

    // Sequence state.
    logic [7:0]             lead_reg, lead_next;
    logic [2:0][7:0]        cont_reg;
    logic [1:0]             held_reg, held_next;
    logic [1:0]             need_reg, need_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic [2:0][7:0]        cont;
    logic                   cont_ok;
    logic                   complete;
    logic                   bad;
    logic [20:0]            cp;
    logic [20:0]            cp_off;
    logic [1:0]             add_k;
    logic                   zero_byte;
    logic [COUNT_WIDTH:0]   count_sum;
    logic [COUNT_WIDTH-1:0] count_sat;
    logic [COUNT_WIDTH+TOTAL_W-1:0] total_ext;

    assign zero_byte = (in_byte == 8'h00);
    assign complete  = (2'(held_reg + 2'd1) == need_reg);

    // Continuation bytes of the sequence, with the incoming byte in its slot.
    always_comb
    begin
        cont_ok = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cont[i] = (held_reg == 2'(i)) ? in_byte : cont_reg[i];
            if ((2'(i) < need_reg) && ((cont[i] & CONT_MASK) != CONT_TAG))
                cont_ok = 1'b0;
        end
    end

    // Assemble the code point and check its range for the sequence length.
    always_comb
    begin
        unique case (need_reg)
            2'd1:
            begin
                cp  = {10'd0, lead_reg[4:0], cont[0][5:0]};
                bad = (cp < TWO_BYTE_MIN);
            end
            2'd2:
            begin
                cp  = {5'd0, lead_reg[3:0], cont[0][5:0], cont[1][5:0]};
                bad = (cp < THREE_BYTE_MIN) || ((cp >= SURR_FIRST) && (cp <= SURR_LAST));
            end
            2'd0, 2'd3:
            begin
                cp  = {lead_reg[2:0], cont[0][5:0], cont[1][5:0], cont[2][5:0]};
                bad = (cp < SUPP_BASE) || (cp > CP_MAX);
            end
        endcase
        cp_off = cp - SUPP_BASE;
    end

    // Units caused by this byte and the next sequence state.
    always_comb
    begin
        batch.units    = '0;
        batch.last_idx = '0;
        batch.term     = 1'b0;
        has_result     = 1'b0;
        add_k          = 2'd0;
        lead_next      = lead_reg;
        held_next      = held_reg;
        need_next      = need_reg;
        priority if (zero_byte)
        begin
            // One replacement for each pending byte, then the terminator.
            add_k = (need_reg != 2'd0) ? 2'(held_reg + 2'd1) : 2'd0;
            for (int i = 0; i < MAX_UNITS; i++)
                batch.units[i] = (3'(i) < {1'b0, add_k}) ? REPL_UNIT : TERM_UNIT;
            batch.last_idx = add_k;
            batch.term     = 1'b1;
            has_result     = 1'b1;
            held_next      = 2'd0;
            need_next      = 2'd0;
        end
        else if (need_reg != 2'd0)
        begin
            held_next = 2'(held_reg + 2'd1);
            if (complete)
            begin
                held_next  = 2'd0;
                need_next  = 2'd0;
                has_result = 1'b1;
                if (!cont_ok || bad)
                begin
                    batch.units[0] = REPL_UNIT;
                    add_k          = 2'd1;
                end
                else if (cp >= SUPP_BASE)
                begin
                    batch.units[0] = HI_SURR_BASE | {6'd0, cp_off[19:10]};
                    batch.units[1] = LO_SURR_BASE | {6'd0, cp[9:0]};
                    batch.last_idx = IDX_W'(1);
                    add_k          = 2'd2;
                end
                else
                begin
                    batch.units[0] = cp[15:0];
                    add_k          = 2'd1;
                end
            end
        end
        else if (!in_byte[7])
        begin
            batch.units[0] = {8'd0, in_byte};
            add_k          = 2'd1;
            has_result     = 1'b1;
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            lead_next = in_byte;
            need_next = 2'd1;
            held_next = 2'd0;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            lead_next = in_byte;
            need_next = 2'd2;
            held_next = 2'd0;
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            lead_next = in_byte;
            need_next = 2'd3;
            held_next = 2'd0;
        end
        else
        begin
            // Stray continuation or invalid lead.
            batch.units[0] = REPL_UNIT;
            add_k          = 2'd1;
            has_result     = 1'b1;
        end

        // Saturating unit counter and the clamped total for the terminator.
        count_sum   = {1'b0, count_reg} + (COUNT_WIDTH+1)'(add_k);
        count_sat   = count_sum[COUNT_WIDTH] ? '1 : count_sum[COUNT_WIDTH-1:0];
        total_ext   = {{TOTAL_W{1'b0}}, count_sat};
        batch.total = (|total_ext[COUNT_WIDTH+TOTAL_W-1:TOTAL_W]) ? '1
                                                                  : total_ext[TOTAL_W-1:0];
        count_next  = zero_byte ? '0 : count_sat;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg  <= '0;
            held_reg  <= '0;
            need_reg  <= '0;
            count_reg <= '0;
        end
        else if (go)
        begin
            lead_reg  <= lead_next;
            held_reg  <= held_next;
            need_reg  <= need_next;
            count_reg <= count_next;
        end
    end

    // Held continuation bytes.
    always_ff @(posedge clk)
    begin
        if (go && !zero_byte && (need_reg != 2'd0))
            cont_reg[held_reg] <= in_byte;
    end

`ifndef NO_ASSERTIONS
    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (need_reg == 2'd0) |-> (held_reg == 2'd0))
        else $error("bytes held with no sequence pending");

    a_held_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        (need_reg != 2'd0) |-> (held_reg < need_reg))
        else $error("held count reached the sequence length");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (go && zero_byte) |=> ((need_reg == 2'd0) && (count_reg == '0)))
        else $error("end of string did not clear the sequence and count");
`endif

endmodule

### hdl/u8u16_emit.sv
module u8u16_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  u8u16_pkg::batch_t batch_in,
    input  logic              little_endian,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       unit,
    output logic              is_terminator,
    output logic [31:0]       unit_total,
    output logic              last
);
    import u8u16_pkg::*;

    logic             valid_reg;
    batch_t           batch_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             take;
    logic             at_end;
    logic [15:0]      raw;

    assign at_end = (idx_reg == batch_reg.last_idx);
    assign take   = valid_reg && out_ready;
    assign free   = !valid_reg || (take && at_end);

    // Sequencer: walk the held units one beat at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take && at_end)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= IDX_W'(idx_reg + 1'b1);
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load)
            batch_reg <= batch_in;
    end

    // Current unit with byte order applied.
    assign raw           = batch_reg.units[idx_reg];
    assign unit          = little_endian ? {raw[7:0], raw[15:8]} : raw;
    assign out_valid     = valid_reg;
    assign is_terminator = batch_reg.term && at_end;
    assign unit_total    = is_terminator ? batch_reg.total : '0;
    assign last          = at_end;

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= batch_reg.last_idx))
        else $error("unit index ran past the end of the beat group");

    a_term_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && batch_reg.term) |-> (batch_reg.units[batch_reg.last_idx] == TERM_UNIT))
        else $error("terminator slot does not hold a zero unit");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("new units loaded over units not yet delivered");
`endif

endmodule

### hdl/utf8_to_utf16_transcoder_top.sv
// Channel  Signals                                      Direction
// in       in_valid, in_ready, in_byte[7:0]             sink
// out      out_valid, out_ready, unit[15:0],            source
//          is_terminator, unit_total[31:0], last
// cfg      cfg_valid, cfg_ready, cfg_little_endian      sink
//
// One input byte per cycle while out_ready is high and each byte causes at most
// one unit; a byte that causes n units holds the output for n beats, one unit per
// cycle while out_ready is high (n up to 4). The output register and its unit
// sequencer set the rate; bytes inside a multi-byte sequence produce no beat.
// A byte register in front of the decoder lets a byte be taken while a result
// waits. Reset is asynchronous and clears all control state; no clearing pass.
module utf8_to_utf16_transcoder_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] unit,
    output logic        is_terminator,
    output logic [31:0] unit_total,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_little_endian
);
    import u8u16_pkg::*;

    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       le_reg;
    logic       go;
    logic       free;
    logic       has_result;
    batch_t     batch;

    // Decode the held byte once the result register can take its units.
    assign go       = byte_valid_reg && free;
    assign in_ready = !byte_valid_reg || go;

    // Input byte register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            byte_valid_reg <= 1'b1;
        else if (go)
            byte_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

    // Byte order register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            le_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            le_reg <= cfg_little_endian;
    end

    u8u16_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .in_byte    (byte_reg),
        .has_result (has_result),
        .batch      (batch)
    );

    u8u16_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (go && has_result),
        .batch_in      (batch),
        .little_endian (le_reg),
        .free          (free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .unit          (unit),
        .is_terminator (is_terminator),
        .unit_total    (unit_total),
        .last          (last)
    );

endmodule
